// ===== rtl/dlwg_pkg.sv =====
// Shared types, constants and waveform tables of the dual LUT waveform generator.
`default_nettype none

package dlwg_pkg;

	// Table positions per waveform period; a power of two, so index arithmetic wraps naturally.
	localparam int unsigned NS        = 256;
	localparam int unsigned PEAK_HALF = 2047;

	localparam int unsigned IDX_W    = $clog2(NS);
	localparam int unsigned HALF_NS  = NS / 2;
	localparam int unsigned FULL     = 2 * PEAK_HALF;
	localparam int unsigned BASE_W   = $clog2(FULL + 1);
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned AMP_W    = 7;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned SHAPE_W  = 2;
	localparam int unsigned OFFSET_W = 8;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned PROD_W   = BASE_W + AMP_W;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

	// Division by the percentage scale through a reciprocal; exact for every product of PROD_W bits.
	localparam int unsigned AMP_SCALE = 100;
	localparam int unsigned DIV_SHIFT = 26;
	localparam logic [DIV_SHIFT-1:0] DIV_RECIP =
		DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'(AMP_SCALE) - 64'd1) / 64'(AMP_SCALE));
	localparam int unsigned SCALED_W = PROD_W + DIV_SHIFT;

	// Waveform codes
	localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 2'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 2'd1;
	localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_A     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_A    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_B     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_B = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_B    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE       = 3'd7;

	typedef struct packed {
		logic [SHAPE_W-1:0]  shape_a;
		logic [AMP_W-1:0]    amplitude_a;
		logic [PERIOD_W-1:0] period_a;
		logic [SHAPE_W-1:0]  shape_b;
		logic [AMP_W-1:0]    amplitude_b;
		logic [PERIOD_W-1:0] period_b;
		logic                follow_enable;
		logic [OFFSET_W-1:0] phase_offset;
	} cfg_t;

	// What one accepted item leaves for the datapath: lookup positions and step flags.
	typedef struct packed {
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
		logic             update_a;
		logic             update_b;
	} step_t;

	typedef logic [NS-1:0][BASE_W-1:0] wave_rom_t;

	// Q30 fixed-point constants for building the sine table.
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
	localparam logic [63:0] Q30_PI      = 64'd3373259426;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	// One sine entry: angle folded into the first quadrant, then the first Taylor term and ten more, each truncated.
	function automatic logic [BASE_W-1:0] sine_entry(int unsigned m);
		logic [63:0] a;
		logic [63:0] a2;
		logic [63:0] term;
		logic [63:0] mix;
		logic [63:0] v;
		longint      sum;
		logic        neg;
		a   = (Q30_TWO_PI * 64'(m)) / 64'(NS);
		neg = 1'b0;
		if (a > Q30_PI) begin
			a   = (a >= Q30_TWO_PI) ? 64'd0 : Q30_TWO_PI - a;
			neg = 1'b1;
		end
		if (a > Q30_HALF_PI) begin
			a = (a >= Q30_PI) ? 64'd0 : Q30_PI - a;
		end
		a2   = (a * a) >> 30;
		term = a;
		sum  = longint'(a);
		for (int k = 1; k <= 10; k++) begin
			term = ((term * a2) >> 30) / 64'((2 * k) * (2 * k + 1));
			if ((k & 1) != 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(Q30_ONE)) begin
			sum = longint'(Q30_ONE);
		end
		mix = neg ? (Q30_ONE - 64'(sum)) : (Q30_ONE + 64'(sum));
		v   = (64'(PEAK_HALF) * mix + 64'd1024) >> 30;
		return v[BASE_W-1:0];
	endfunction

	function automatic wave_rom_t build_sine_rom();
		wave_rom_t rom;
		for (int unsigned i = 0; i < NS; i++) begin
			rom[i] = sine_entry(i);
		end
		return rom;
	endfunction

	function automatic wave_rom_t build_triangle_rom();
		wave_rom_t rom;
		for (int unsigned i = 0; i < NS; i++) begin
			if (i < HALF_NS) begin
				rom[i] = BASE_W'((FULL * i) / HALF_NS);
			end else begin
				rom[i] = BASE_W'((FULL * (NS - i)) / HALF_NS);
			end
		end
		return rom;
	endfunction

	localparam wave_rom_t SINE_ROM     = build_sine_rom();
	localparam wave_rom_t TRIANGLE_ROM = build_triangle_rom();

endpackage

`default_nettype wire

// ===== rtl/dlwg_cfg_regs.sv =====
// Configuration register file of the dual LUT waveform generator.
`default_nettype none

module dlwg_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [dlwg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dlwg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dlwg_pkg::cfg_t                        cfg
);

	dlwg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_a       <= dlwg_pkg::SHAPE_SINE;
			cfg_q.amplitude_a   <= dlwg_pkg::AMP_W'(dlwg_pkg::AMP_SCALE);
			cfg_q.period_a      <= dlwg_pkg::PERIOD_W'(624);
			cfg_q.shape_b       <= dlwg_pkg::SHAPE_SINE;
			cfg_q.amplitude_b   <= dlwg_pkg::AMP_W'(dlwg_pkg::AMP_SCALE);
			cfg_q.period_b      <= dlwg_pkg::PERIOD_W'(624);
			cfg_q.follow_enable <= 1'b0;
			cfg_q.phase_offset  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dlwg_pkg::CFG_SHAPE_A:     cfg_q.shape_a       <= cfg_data[dlwg_pkg::SHAPE_W-1:0];
				dlwg_pkg::CFG_AMPLITUDE_A: cfg_q.amplitude_a   <= cfg_data[dlwg_pkg::AMP_W-1:0];
				dlwg_pkg::CFG_PERIOD_A:    cfg_q.period_a      <= cfg_data[dlwg_pkg::PERIOD_W-1:0];
				dlwg_pkg::CFG_SHAPE_B:     cfg_q.shape_b       <= cfg_data[dlwg_pkg::SHAPE_W-1:0];
				dlwg_pkg::CFG_AMPLITUDE_B: cfg_q.amplitude_b   <= cfg_data[dlwg_pkg::AMP_W-1:0];
				dlwg_pkg::CFG_PERIOD_B:    cfg_q.period_b      <= cfg_data[dlwg_pkg::PERIOD_W-1:0];
				dlwg_pkg::CFG_FOLLOW:      cfg_q.follow_enable <= cfg_data[0];
				dlwg_pkg::CFG_PHASE:       cfg_q.phase_offset  <= cfg_data[dlwg_pkg::OFFSET_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/dlwg_sequencer.sv =====
// Tick counters and table indexes of both channels, stepped once per accepted item.
`default_nettype none

module dlwg_sequencer (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic       restart,
	input  dlwg_pkg::cfg_t  cfg,
	output dlwg_pkg::step_t step
);

	logic [dlwg_pkg::PERIOD_W-1:0] count_a_q;
	logic [dlwg_pkg::PERIOD_W-1:0] count_b_q;
	logic [dlwg_pkg::IDX_W-1:0]    idx_a_q;
	logic [dlwg_pkg::IDX_W-1:0]    idx_b_q;

	logic [dlwg_pkg::PERIOD_W-1:0] count_a_next;
	logic [dlwg_pkg::PERIOD_W-1:0] count_b_next;
	logic [dlwg_pkg::IDX_W-1:0]    idx_a_next;
	logic [dlwg_pkg::IDX_W-1:0]    idx_b_next;
	logic [dlwg_pkg::PERIOD_W-1:0] period_b_eff;
	logic                          hit_a;
	logic                          hit_b;

	always_comb begin
		// In follow mode channel B keeps its own counter but runs at channel A's rate.
		period_b_eff = cfg.follow_enable ? cfg.period_a : cfg.period_b;
		hit_a = (count_a_q >= cfg.period_a);
		hit_b = (count_b_q >= period_b_eff);

		if (restart) begin
			count_a_next = '0;
			count_b_next = '0;
			idx_a_next   = '0;
			idx_b_next   = '0;
			step.update_a = 1'b0;
			step.update_b = 1'b0;
		end else begin
			count_a_next = hit_a ? '0 : count_a_q + 1'b1;
			count_b_next = hit_b ? '0 : count_b_q + 1'b1;
			idx_a_next   = hit_a ? idx_a_q + 1'b1 : idx_a_q;
			idx_b_next   = hit_b ? idx_b_q + 1'b1 : idx_b_q;
			step.update_a = hit_a;
			step.update_b = hit_b;
		end

		step.idx_a = idx_a_next;
		// The table size is a power of two, so truncating the offset takes it modulo the size.
		step.idx_b = cfg.follow_enable ?
			idx_b_next - dlwg_pkg::IDX_W'(cfg.phase_offset) : idx_b_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= '0;
			count_b_q <= '0;
			idx_a_q   <= '0;
			idx_b_q   <= '0;
		end else if (accept) begin
			count_a_q <= count_a_next;
			count_b_q <= count_b_next;
			idx_a_q   <= idx_a_next;
			idx_b_q   <= idx_b_next;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dlwg_shaper.sv =====
// Base waveform lookup for one channel, multiplied by the amplitude percentage.
`default_nettype none

module dlwg_shaper (
	input  wire logic [dlwg_pkg::SHAPE_W-1:0] shape,
	input  wire logic [dlwg_pkg::AMP_W-1:0]   amplitude,
	input  wire logic [dlwg_pkg::IDX_W-1:0]   idx,
	output logic      [dlwg_pkg::PROD_W-1:0]  product
);

	logic [dlwg_pkg::BASE_W-1:0] base;

	always_comb begin
		case (shape)
			dlwg_pkg::SHAPE_SINE:     base = dlwg_pkg::SINE_ROM[idx];
			dlwg_pkg::SHAPE_SQUARE:   base = (idx < dlwg_pkg::IDX_W'(dlwg_pkg::HALF_NS)) ?
				dlwg_pkg::BASE_W'(dlwg_pkg::FULL) : '0;
			dlwg_pkg::SHAPE_TRIANGLE: base = dlwg_pkg::TRIANGLE_ROM[idx];
			default:                  base = '0;
		endcase
		product = dlwg_pkg::PROD_W'(base) * dlwg_pkg::PROD_W'(amplitude);
	end

endmodule

`default_nettype wire

// ===== rtl/dlwg_scaler.sv =====
// Divides a scaled sample by the percentage scale and saturates it to the DAC range.
`default_nettype none

module dlwg_scaler (
	input  wire logic [dlwg_pkg::PROD_W-1:0]   product,
	output logic      [dlwg_pkg::SAMPLE_W-1:0] sample
);

	logic [dlwg_pkg::SCALED_W-1:0] scaled;
	logic [dlwg_pkg::PROD_W-1:0]   quotient;

	always_comb begin
		// The reciprocal is rounded up; the error stays below one hundredth over the input range.
		scaled   = dlwg_pkg::SCALED_W'(product) * dlwg_pkg::SCALED_W'(dlwg_pkg::DIV_RECIP);
		quotient = dlwg_pkg::PROD_W'(scaled >> dlwg_pkg::DIV_SHIFT);
		sample   = (quotient > dlwg_pkg::PROD_W'(dlwg_pkg::SAMPLE_MAX)) ?
			dlwg_pkg::SAMPLE_MAX : quotient[dlwg_pkg::SAMPLE_W-1:0];
	end

endmodule

`default_nettype wire

// ===== rtl/dual_lut_waveform_generator.sv =====
// Top level of the two-channel lookup-table waveform generator.
//
// Each accepted item is one sample-clock tick (or a restart) and yields exactly one result item
// carrying both channels' DAC codes and step flags. The block takes one item every cycle while
// results are taken; the tick counters and indexes step as the item is taken into the first
// stage, the waveform lookup and amplitude multiply fill the second stage, and the divide by
// one hundred with saturation fills the output register. Each stage moves on its own, so an
// empty stage still takes work while a finished result waits. The sine and triangle tables are
// constant logic computed at elaboration, so there is no loading or clearing after reset.
`default_nettype none

module dual_lut_waveform_generator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [dlwg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [dlwg_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               restart,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [dlwg_pkg::SAMPLE_W-1:0]      sample_a,
	output logic      [dlwg_pkg::SAMPLE_W-1:0]      sample_b,
	output logic                                    update_a,
	output logic                                    update_b
);

	dlwg_pkg::cfg_t  cfg;
	dlwg_pkg::step_t step;

	logic accept;
	logic ready_s2;
	logic ready_s3;

	logic                          valid_s1;
	dlwg_pkg::step_t               step_s1;
	logic                          valid_s2;
	logic [dlwg_pkg::PROD_W-1:0]   prod_a_s2;
	logic [dlwg_pkg::PROD_W-1:0]   prod_b_s2;
	logic                          update_a_s2;
	logic                          update_b_s2;
	logic                          valid_s3;
	logic [dlwg_pkg::SAMPLE_W-1:0] sample_a_s3;
	logic [dlwg_pkg::SAMPLE_W-1:0] sample_b_s3;
	logic                          update_a_s3;
	logic                          update_b_s3;

	logic [dlwg_pkg::PROD_W-1:0]   prod_a;
	logic [dlwg_pkg::PROD_W-1:0]   prod_b;
	logic [dlwg_pkg::SAMPLE_W-1:0] sample_a_div;
	logic [dlwg_pkg::SAMPLE_W-1:0] sample_b_div;
	logic [dlwg_pkg::SHAPE_W-1:0]  shape_b_eff;
	logic [dlwg_pkg::AMP_W-1:0]    amplitude_b_eff;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign in_ready = !valid_s1 || ready_s2;
	assign accept   = in_valid && in_ready;

	dlwg_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dlwg_sequencer u_sequencer (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.restart (restart),
		.cfg     (cfg),
		.step    (step)
	);

	// In follow mode channel B draws channel A's waveform.
	assign shape_b_eff     = cfg.follow_enable ? cfg.shape_a : cfg.shape_b;
	assign amplitude_b_eff = cfg.follow_enable ? cfg.amplitude_a : cfg.amplitude_b;

	dlwg_shaper u_shaper_a (
		.shape     (cfg.shape_a),
		.amplitude (cfg.amplitude_a),
		.idx       (step_s1.idx_a),
		.product   (prod_a)
	);

	dlwg_shaper u_shaper_b (
		.shape     (shape_b_eff),
		.amplitude (amplitude_b_eff),
		.idx       (step_s1.idx_b),
		.product   (prod_b)
	);

	dlwg_scaler u_scaler_a (
		.product (prod_a_s2),
		.sample  (sample_a_div)
	);

	dlwg_scaler u_scaler_b (
		.product (prod_b_s2),
		.sample  (sample_b_div)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
		end
		if (ready_s2 && valid_s1) begin
			prod_a_s2   <= prod_a;
			prod_b_s2   <= prod_b;
			update_a_s2 <= step_s1.update_a;
			update_b_s2 <= step_s1.update_b;
		end
		if (ready_s3 && valid_s2) begin
			sample_a_s3 <= sample_a_div;
			sample_b_s3 <= sample_b_div;
			update_a_s3 <= update_a_s2;
			update_b_s3 <= update_b_s2;
		end
	end

	assign out_valid = valid_s3;
	assign sample_a  = sample_a_s3;
	assign sample_b  = sample_b_s3;
	assign update_a  = update_a_s3;
	assign update_b  = update_b_s3;

endmodule

`default_nettype wire

// ===== rtl/dlwg_checker.sv =====
// Port-level checks of the dual LUT waveform generator and their binding to the top level.
`default_nettype none

module dlwg_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [dlwg_pkg::SAMPLE_W-1:0] sample_a,
	input wire logic [dlwg_pkg::SAMPLE_W-1:0] sample_b,
	input wire logic                          update_a,
	input wire logic                          update_b
);

	// A result that is not taken stays on the port unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_a) && $stable(sample_b)
			&& $stable(update_a) && $stable(update_b))
		else $error("stalled result changed");

	// Input is refused only when every stage is full behind a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused while the output is free");

	// A result appearing on an empty output belongs to an item that was taken at the input and passed through every stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3))
		else $error("result without an item taken three cycles before");

endmodule

bind dual_lut_waveform_generator dlwg_checker u_dlwg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample_a  (sample_a),
	.sample_b  (sample_b),
	.update_a  (update_a),
	.update_b  (update_b)
);

`default_nettype wire

// ===== tb/dac_sample_checker.sv =====
// Checker that predicts both channels' DAC codes for every accepted item and compares the results.
module dac_sample_checker
	import dlwg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic                  restart,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic [SAMPLE_W-1:0]   sample_a,
	input  wire logic [SAMPLE_W-1:0]   sample_b,
	input  wire logic                  update_a,
	input  wire logic                  update_b,
	output int                         mismatches,
	output int                         pending
);

	localparam logic [63:0] TURN_Q30         = 64'd6746518852;
	localparam logic [63:0] HALF_TURN_Q30    = 64'd3373259426;
	localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
	localparam logic [63:0] UNITY_Q30        = 64'd1073741824;
	localparam int unsigned MID_LEVEL        = 2047;
	localparam int unsigned TOP_LEVEL        = 4094;
	localparam int unsigned HALF_TABLE       = NS / 2;
	localparam int unsigned PERCENT          = 100;
	localparam int unsigned CODE_CEILING     = 4095;

	typedef struct packed {
		logic [SAMPLE_W-1:0] code_a;
		logic [SAMPLE_W-1:0] code_b;
		logic                step_a;
		logic                step_b;
	} dac_pair_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] ticks;
		logic [IDX_W-1:0]    pos;
		logic                stepped;
	} chan_state_t;

	logic [SAMPLE_W-1:0] sine_lut [NS];
	logic [SHAPE_W-1:0]  cur_shape_a, cur_shape_b;
	logic [AMP_W-1:0]    cur_amp_a, cur_amp_b;
	logic [PERIOD_W-1:0] cur_period_a, cur_period_b;
	logic                cur_follow;
	logic [OFFSET_W-1:0] cur_phase;
	chan_state_t         chan_a, chan_b;
	dac_pair_t           expected_codes [$];

	// Sine in unsigned Q30: fold the angle into the first quadrant, then the first Taylor term and ten more, truncated.
	function automatic logic [SAMPLE_W-1:0] sine_code(int unsigned pos);
		logic [63:0] ang;
		logic [63:0] ang_sq;
		logic [63:0] term;
		logic [63:0] mix;
		logic [63:0] level;
		longint      acc;
		logic        lower_half;
		ang = (TURN_Q30 * 64'(pos)) / 64'(NS);
		lower_half = 1'b0;
		if (ang > HALF_TURN_Q30) begin
			ang = (ang >= TURN_Q30) ? 64'd0 : TURN_Q30 - ang;
			lower_half = 1'b1;
		end
		if (ang > QUARTER_TURN_Q30) begin
			ang = (ang >= HALF_TURN_Q30) ? 64'd0 : HALF_TURN_Q30 - ang;
		end
		ang_sq = (ang * ang) >> 30;
		term = ang;
		acc = longint'(ang);
		for (int k = 1; k <= 10; k++) begin
			term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(UNITY_Q30)) begin
			acc = longint'(UNITY_Q30);
		end
		mix = lower_half ? (UNITY_Q30 - 64'(acc)) : (UNITY_Q30 + 64'(acc));
		level = (64'(MID_LEVEL) * mix + 64'd1024) >> 30;
		return level[SAMPLE_W-1:0];
	endfunction

	function automatic int unsigned wave_level(logic [SHAPE_W-1:0] shape, logic [IDX_W-1:0] pos);
		case (shape)
			SHAPE_SINE: begin
				return sine_lut[pos];
			end
			SHAPE_SQUARE: begin
				return (pos < HALF_TABLE) ? TOP_LEVEL : 0;
			end
			SHAPE_TRIANGLE: begin
				if (pos < HALF_TABLE) begin
					return (TOP_LEVEL * int'(pos)) / HALF_TABLE;
				end
				return (TOP_LEVEL * (NS - int'(pos))) / HALF_TABLE;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] dac_code(logic [SHAPE_W-1:0] shape,
			logic [AMP_W-1:0] amp, logic [IDX_W-1:0] pos);
		int unsigned level;
		level = (wave_level(shape, pos) * int'(amp)) / PERCENT;
		return (level > CODE_CEILING) ? SAMPLE_MAX : level[SAMPLE_W-1:0];
	endfunction

	// A tick that finds the count at or above the period wraps the count and steps the position.
	function automatic chan_state_t next_channel(chan_state_t cur, logic [PERIOD_W-1:0] period);
		chan_state_t nxt;
		if (cur.ticks >= period) begin
			nxt.ticks   = '0;
			nxt.pos     = cur.pos + 1'b1;
			nxt.stepped = 1'b1;
		end else begin
			nxt.ticks   = cur.ticks + 1'b1;
			nxt.pos     = cur.pos;
			nxt.stepped = 1'b0;
		end
		return nxt;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	initial begin
		for (int i = 0; i < NS; i++) begin
			sine_lut[i] = sine_code(i);
		end
	end

	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		dac_pair_t want;
		if (!arst_n) begin
			cur_shape_a  = SHAPE_SINE;
			cur_amp_a    = AMP_W'(100);
			cur_period_a = PERIOD_W'(624);
			cur_shape_b  = SHAPE_SINE;
			cur_amp_b    = AMP_W'(100);
			cur_period_b = PERIOD_W'(624);
			cur_follow   = 1'b0;
			cur_phase    = '0;
			chan_a       = '0;
			chan_b       = '0;
			expected_codes.delete();
			mismatches   = 0;
			pending     <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_SHAPE_A:     cur_shape_a  = cfg_data[SHAPE_W-1:0];
					CFG_AMPLITUDE_A: cur_amp_a    = cfg_data[AMP_W-1:0];
					CFG_PERIOD_A:    cur_period_a = cfg_data[PERIOD_W-1:0];
					CFG_SHAPE_B:     cur_shape_b  = cfg_data[SHAPE_W-1:0];
					CFG_AMPLITUDE_B: cur_amp_b    = cfg_data[AMP_W-1:0];
					CFG_PERIOD_B:    cur_period_b = cfg_data[PERIOD_W-1:0];
					CFG_FOLLOW:      cur_follow   = cfg_data[0];
					CFG_PHASE:       cur_phase    = cfg_data[OFFSET_W-1:0];
					default: ;
				endcase
			end

			// Results are retired before the new prediction, so nothing can match its own item.
			if (out_valid && out_ready) begin
				if (expected_codes.size() == 0) begin
					report_mismatch("result with no item outstanding, sample_a", sample_a, 0);
				end else begin
					want = expected_codes.pop_front();
					if (sample_a !== want.code_a) begin
						report_mismatch("sample_a", sample_a, want.code_a);
					end
					if (sample_b !== want.code_b) begin
						report_mismatch("sample_b", sample_b, want.code_b);
					end
					if (update_a !== want.step_a) begin
						report_mismatch("update_a", update_a, want.step_a);
					end
					if (update_b !== want.step_b) begin
						report_mismatch("update_b", update_b, want.step_b);
					end
				end
			end

			if (in_valid && in_ready) begin
				if (restart) begin
					chan_a = '0;
					chan_b = '0;
				end else begin
					chan_a = next_channel(chan_a, cur_period_a);
					chan_b = next_channel(chan_b, cur_follow ? cur_period_a : cur_period_b);
				end
				want.step_a = chan_a.stepped;
				want.step_b = chan_b.stepped;
				want.code_a = dac_code(cur_shape_a, cur_amp_a, chan_a.pos);
				if (cur_follow) begin
					want.code_b = dac_code(cur_shape_a, cur_amp_a, IDX_W'(chan_b.pos - cur_phase));
				end else begin
					want.code_b = dac_code(cur_shape_b, cur_amp_b, chan_b.pos);
				end
				expected_codes.push_back(want);
			end
			pending <= expected_codes.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives ticks, restarts and register writes into the waveform generator.
module tb;
	import dlwg_pkg::*;

	localparam logic [SHAPE_W-1:0] SHAPE_UNUSED = 2'd3;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_ITEMS = 750;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  restart   = 1'b0;
	logic                  out_ready = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic [SAMPLE_W-1:0]   sample_a;
	logic [SAMPLE_W-1:0]   sample_b;
	logic                  update_a;
	logic                  update_b;
	int                    mismatches;
	int                    pending;
	int                    items_sent = 0;
	int                    ready_mode = 0;
	int                    mode_left  = 0;

	always #4 clk = ~clk;

	dual_lut_waveform_generator uut (.*);

	dac_sample_checker sample_check (.*);

	// The receiver switches between always ready, coin-toss stalls and a fixed one-in-five pattern.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			ready_mode <= $urandom_range(0, 2);
			mode_left  <= $urandom_range(20, 100);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (ready_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ($urandom_range(0, 1) == 1);
			default: out_ready <= (mode_left % 5 == 0);
		endcase
	end

	task automatic send_item(input logic rs);
		in_valid <= 1'b1;
		restart  <= rs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic tick_burst(input int count, input int restart_pct);
		int burst_left;
		int gap;
		burst_left = $urandom_range(1, 40);
		for (int n = 0; n < count; n++) begin
			send_item($urandom_range(0, 99) < restart_pct);
			burst_left--;
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 40);
			end
		end
	endtask

	// Registers only change once every outstanding result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int unsigned pick_period();
		case ($urandom_range(0, 9))
			0:       return 65535;
			1:       return $urandom_range(4, 40);
			2:       return $urandom_range(0, 65535);
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	function automatic int unsigned pick_amplitude();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return 100;
			2:       return $urandom_range(101, 127);
			default: return $urandom_range(0, 100);
		endcase
	endfunction

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int random_goal;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, with a restart in the middle of the stream.
		tick_burst(3, 0);
		send_item(1'b1);
		tick_burst(2, 0);

		// Every tick steps A; square over full scale saturates, zero amplitude on B.
		drain();
		write_reg(CFG_SHAPE_A, SHAPE_SQUARE);
		write_reg(CFG_AMPLITUDE_A, 127);
		write_reg(CFG_PERIOD_A, 0);
		write_reg(CFG_SHAPE_B, SHAPE_TRIANGLE);
		write_reg(CFG_AMPLITUDE_B, 0);
		write_reg(CFG_PERIOD_B, 1);
		tick_burst(4, 0);

		// Unused shape code on A with the longest period; B builds up a count.
		drain();
		write_reg(CFG_SHAPE_A, SHAPE_UNUSED);
		write_reg(CFG_PERIOD_A, 65535);
		write_reg(CFG_SHAPE_B, SHAPE_SINE);
		write_reg(CFG_AMPLITUDE_B, 100);
		write_reg(CFG_PERIOD_B, 10);
		tick_burst(6, 0);

		// Lowering the period below the running count makes the next tick step at once.
		drain();
		write_reg(CFG_PERIOD_B, 2);
		tick_burst(2, 0);
		send_item(1'b1);

		// B follows A with the largest phase offset, then follow mode ends.
		drain();
		write_reg(CFG_SHAPE_A, SHAPE_TRIANGLE);
		write_reg(CFG_AMPLITUDE_A, 100);
		write_reg(CFG_PERIOD_A, 0);
		write_reg(CFG_FOLLOW, 1);
		write_reg(CFG_PHASE, 255);
		tick_burst(5, 0);
		drain();
		write_reg(CFG_FOLLOW, 0);
		tick_burst(1, 0);

		random_goal = items_sent + RANDOM_ITEMS;
		while (items_sent < random_goal) begin
			drain();
			write_reg(CFG_SHAPE_A, $urandom_range(0, 3));
			write_reg(CFG_AMPLITUDE_A, pick_amplitude());
			write_reg(CFG_PERIOD_A, pick_period());
			write_reg(CFG_SHAPE_B, $urandom_range(0, 3));
			write_reg(CFG_AMPLITUDE_B, pick_amplitude());
			write_reg(CFG_PERIOD_B, pick_period());
			write_reg(CFG_FOLLOW, $urandom_range(0, 1));
			case ($urandom_range(0, 3))
				0:       write_reg(CFG_PHASE, 0);
				1:       write_reg(CFG_PHASE, 255);
				default: write_reg(CFG_PHASE, $urandom_range(0, 255));
			endcase
			tick_burst($urandom_range(30, 120), 2);
		end

		drain();
		if (mismatches == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
